// ===== src/pixel_replicate_decimate_scaler_core_assert.svh =====
// Assertion macros shared by the scaler RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef PIXEL_REPLICATE_DECIMATE_SCALER_CORE_ASSERT_SVH
`define PIXEL_REPLICATE_DECIMATE_SCALER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition must hold on every clock edge out of reset.
`define PRDS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scaler assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define PRDS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scaler assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PRDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scaler assertion failed");
`else
`define PRDS_ASSERT(label, cond)
`define PRDS_ASSERT_IMPL(label, ante, cons)
`define PRDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/prds_pkg.sv =====
// Shared types and constants of the pixel scaler.
// No dependencies; imported by every scaler module.
package prds_pkg;

  localparam int PIX_W       = 24;
  localparam int PAD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [12:0] row_pixels;
    logic        shrink_mode;
    logic [3:0]  scale_factor;
  } cfg_t;

endpackage

// ===== src/prds_front.sv =====
// Front end of the scaler: takes pixels, tracks row and column position and
// turns each pixel into a job (copies and padding). Depends on prds_pkg.
module prds_front import prds_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_FACTOR     = 8,
  parameter int CP_W           = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic             q_full,
  output logic             in_ready,
  output logic             push,
  output logic [CP_W-1:0]  job_copies,
  output logic [PAD_W-1:0] job_pad
);

  localparam int COL_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int PH_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int RW    = $clog2(MAX_ROW_PIXELS + 1);
  localparam int LW    = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [PH_W-1:0]  rph_r, rph_nxt;
  logic [PH_W-1:0]  cph_r, cph_nxt;
  logic [1:0]       em_r, em_nxt;

  logic [CP_W-1:0]  f_eff;
  logic [LW-1:0]    rp_ext;
  logic [LW-1:0]    len_eff;
  logic [4:0]       sf_ext;
  logic             last;
  logic             row_kept;
  logic             keep;
  logic [1:0]       em_new;
  logic             accept;

  assign sf_ext = {1'b0, cfg.scale_factor};
  assign rp_ext = LW'(cfg.row_pixels);

  always_comb begin
    if (cfg.scale_factor == 4'd0) begin
      f_eff = CP_W'(1);
    end else if (sf_ext > 5'(MAX_FACTOR)) begin
      f_eff = CP_W'(MAX_FACTOR);
    end else begin
      f_eff = CP_W'(cfg.scale_factor);
    end
    if (cfg.row_pixels == '0) begin
      len_eff = LW'(1);
    end else if (rp_ext > LW'(MAX_ROW_PIXELS)) begin
      len_eff = LW'(MAX_ROW_PIXELS);
    end else begin
      len_eff = rp_ext;
    end
  end

  assign last     = (LW'(col_r) + LW'(1)) >= len_eff;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt    = col_r;
    rph_nxt    = rph_r;
    cph_nxt    = cph_r;
    em_nxt     = em_r;
    job_copies = '0;
    job_pad    = '0;
    row_kept   = 1'b1;
    keep       = 1'b0;
    em_new     = em_r;
    if (!cfg.shrink_mode) begin
      job_copies = f_eff;
      em_new     = em_r + 2'(f_eff);
    end else begin
      row_kept   = (rph_r == '0);
      keep       = row_kept && (cph_r == '0);
      job_copies = CP_W'(keep);
      em_new     = em_r + 2'(keep);
      cph_nxt    = ((CP_W'(cph_r) + CP_W'(1)) >= f_eff) ? '0 : cph_r + PH_W'(1);
    end
    if (last) begin
      // Padding bytes to a four-byte boundary equal the pixel count mod 4.
      job_pad = row_kept ? em_new : '0;
      if (cfg.shrink_mode) begin
        rph_nxt = ((CP_W'(rph_r) + CP_W'(1)) >= f_eff) ? '0 : rph_r + PH_W'(1);
      end else begin
        rph_nxt = '0;
      end
      col_nxt = '0;
      cph_nxt = '0;
      em_nxt  = '0;
    end else begin
      col_nxt = col_r + COL_W'(1);
      em_nxt  = em_new;
    end
  end

  assign push = accept && ((job_copies != '0) || (job_pad != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      rph_r <= '0;
      cph_r <= '0;
      em_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      rph_r <= rph_nxt;
      cph_r <= cph_nxt;
      em_r  <= em_nxt;
    end
  end

endmodule

// ===== src/prds_queue.sv =====
// Small job queue between front and back of the scaler.
// Depends on prds_pkg and the assertion macro header.
`include "pixel_replicate_decimate_scaler_core_assert.svh"
module prds_queue import prds_pkg::*; #(
  parameter int W     = 30,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [AW:0]  wr_ptr_r, rd_ptr_r;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]) && (wr_ptr_r[AW] != rd_ptr_r[AW]);
  assign rd_data = mem_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (AW+1)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (AW+1)'(1);
      end
    end
  end

  `PRDS_ASSERT(a_no_push_full, !(push && full))
  `PRDS_ASSERT(a_no_pop_empty, !(pop && empty))
  `PRDS_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

// ===== src/prds_back.sv =====
// Scaler back end (uses prds_pkg): plays each job out as pixel copies, then
// padding bytes into an output register, one result per cycle unless stalled.
`include "pixel_replicate_decimate_scaler_core_assert.svh"
module prds_back import prds_pkg::*; #(
  parameter int CP_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [CP_W-1:0]  job_copies,
  input  logic [PAD_W-1:0] job_pad,
  input  pixel_t           job_pix,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pixel_t           out_pix,
  output logic             out_kind,
  output logic             out_last
);

  logic             act_r, act_nxt;
  logic [CP_W-1:0]  copies_r, copies_nxt;
  logic [PAD_W-1:0] pads_r, pads_nxt;
  pixel_t           pix_r, pix_nxt;
  logic             ov_r, ov_nxt;
  pixel_t           opix_r, opix_nxt;
  logic             okind_r, okind_nxt;
  logic             olast_r, olast_nxt;

  logic             advance;
  logic             emit;
  logic             is_last;

  assign advance = !ov_r || out_ready;
  assign emit    = act_r && advance;
  assign is_last = ((copies_r == CP_W'(1)) && (pads_r == '0)) ||
                   ((copies_r == '0) && (pads_r == PAD_W'(1)));
  assign pop     = !q_empty && (!act_r || (emit && is_last));

  always_comb begin
    act_nxt    = act_r;
    copies_nxt = copies_r;
    pads_nxt   = pads_r;
    pix_nxt    = pix_r;
    ov_nxt     = advance ? 1'b0 : ov_r;
    opix_nxt   = opix_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      olast_nxt = is_last;
      if (copies_r != '0) begin
        opix_nxt   = pix_r;
        okind_nxt  = KIND_PIXEL;
        copies_nxt = copies_r - CP_W'(1);
      end else begin
        opix_nxt  = '0;
        okind_nxt = KIND_PAD;
        pads_nxt  = pads_r - PAD_W'(1);
      end
      if (is_last) begin
        act_nxt = 1'b0;
      end
    end
    if (pop) begin
      act_nxt    = 1'b1;
      copies_nxt = job_copies;
      pads_nxt   = job_pad;
      pix_nxt    = job_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copies_r <= copies_nxt;
    pads_r   <= pads_nxt;
    pix_r    <= pix_nxt;
    opix_r   <= opix_nxt;
    okind_r  <= okind_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid = ov_r;
  assign out_pix   = opix_r;
  assign out_kind  = okind_r;
  assign out_last  = olast_r;

  `PRDS_ASSERT_IMPL(a_job_nonempty, pop, (job_copies != '0) || (job_pad != '0))
  `PRDS_ASSERT_IMPL(a_active_has_work, act_r, (copies_r != '0) || (pads_r != '0))
  `PRDS_ASSERT_IMPL(a_pad_is_zero, ov_r && (okind_r == KIND_PAD), opix_r == '0)

endmodule

// ===== src/pixel_replicate_decimate_scaler_core.sv =====
// Top level of the nearest-neighbor integer pixel scaler.
// Depends on prds_pkg, prds_front, prds_queue and prds_back.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_tvalid / in_tready  | in_tdata: red, green, blue
//  out     | output    | out_tvalid / out_tready| out_tdata: red, green, blue;
//          |           |                        | out_tuser: kind; out_tlast: final
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The back end emits one result per cycle unless out_tready stalls it. An item
// yields scale_factor copies plus up to three padding bytes at the end
// of a row in upscale mode; in downscale mode at most one copy, again followed by
// up to three padding bytes when the item closes a kept row.
// Items that produce nothing are absorbed without queuing.
// The front accepts an item every cycle while the four-entry job queue has room;
// a stalled output holds its register and backs up into the queue.
// Reset is synchronous, active low; it restores the register defaults (row of
// one pixel, replicate mode, factor one) and starts at the first pixel of a row.
module pixel_replicate_decimate_scaler_core import prds_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_FACTOR     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                  out_tuser,  // [0] kind: 0 pixel, 1 padding byte
  output logic                  out_tlast,  // last result caused by an input item
  // Register write port.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Copy count holds values up to the largest factor.
  localparam int CP_W  = $clog2(MAX_FACTOR + 1);
  localparam int JOB_W = CP_W + PAD_W + PIX_W;

  cfg_t             cfg_r;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  logic [CP_W-1:0]  f_copies;
  logic [PAD_W-1:0] f_pad;
  logic [JOB_W-1:0] q_wr;
  logic [JOB_W-1:0] q_rd;
  pixel_t           out_pix;

  // Registers are always writable; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_pixels   <= CFG_DATA_W'(1);
      cfg_r.shrink_mode  <= 1'b0;
      cfg_r.scale_factor <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_PIXELS:   cfg_r.row_pixels   <= cfg_data;
        REG_SHRINK_MODE:  cfg_r.shrink_mode  <= cfg_data[0];
        REG_SCALE_FACTOR: cfg_r.scale_factor <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front end classifies each pixel into copies and padding.
  prds_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_FACTOR    (MAX_FACTOR),
    .CP_W          (CP_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .push      (push),
    .job_copies(f_copies),
    .job_pad   (f_pad)
  );

  assign q_wr = {f_copies, f_pad, in_tdata};

  prds_queue #(
    .W    (JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(q_wr),
    .pop    (pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end plays jobs out one result per cycle unless the output stalls.
  prds_back #(
    .CP_W(CP_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .job_copies(q_rd[JOB_W-1 -: CP_W]),
    .job_pad   (q_rd[PIX_W +: PAD_W]),
    .job_pix   (pixel_t'(q_rd[PIX_W-1:0])),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = out_pix;

endmodule
